@@ hw/rtl/coc_pkg.sv @@
// shared types and constants for the circle obstacle clearance block
`timescale 1ns / 1ps
package coc_pkg;

	// field widths
	localparam int ACT_W    = 2;
	localparam int POS_W    = 16;
	localparam int RAD_W    = 10;
	localparam int MRG_W    = 10;
	localparam int MAXC_W   = 16;
	localparam int CLR_W    = 17;
	localparam int CNTO_W   = 7;

	// configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SAFETY_MARGIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CLEARANCE = 1'd1;

	// action codes
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

	// datapath widths
	localparam int DIF_W   = POS_W + 1;          // coordinate difference
	localparam int SQ1_W   = 2 * POS_W;          // one squared difference
	localparam int SQ_W    = SQ1_W + 1;          // sum of squares
	localparam int RT_W    = (SQ_W + 1) / 2;     // integer root
	localparam int ISQ_W   = SQ_W + 2;           // root unit working width
	localparam int DST_W   = RT_W + 1;           // signed clearance per obstacle
	localparam int ENTRY_W = 2 * POS_W + RAD_W;  // stored x, y, radius

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

endpackage

@@ hw/rtl/coc_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module coc_ram #(
	parameter int WIDTH  = 42,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/coc_isqrt.sv @@
// pipelined floor integer square root, one result bit per stage, with a sideband tag
`timescale 1ns / 1ps
module coc_isqrt #(
	parameter int TAG_W = 11
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  logic [coc_pkg::SQ_W-1:0] in_val,
	input  logic [TAG_W-1:0]         in_tag,
	output logic                     out_vld,
	output logic [coc_pkg::RT_W-1:0] out_root,
	output logic [TAG_W-1:0]         out_tag
);

	import coc_pkg::*;

	logic [ISQ_W-1:0] rem_s [RT_W];
	logic [ISQ_W-1:0] res_s [RT_W];
	logic [TAG_W-1:0] tag_s [RT_W];
	logic             vld_s [RT_W];

	for (genvar k = 0; k < RT_W; k++) begin : g_stage
		localparam logic [ISQ_W-1:0] BIT =
			{{(ISQ_W-1){1'b0}}, 1'b1} << (2 * (RT_W - 1 - k));

		logic [ISQ_W-1:0] rem_in;
		logic [ISQ_W-1:0] res_in;
		logic [TAG_W-1:0] tag_in;
		logic             vld_in;
		logic [ISQ_W-1:0] trial;
		logic [ISQ_W-1:0] rem_nx;
		logic [ISQ_W-1:0] res_nx;

		if (k == 0) begin : g_first
			assign rem_in = ISQ_W'(in_val);
			assign res_in = '0;
			assign tag_in = in_tag;
			assign vld_in = in_vld;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
			assign tag_in = tag_s[k-1];
			assign vld_in = vld_s[k-1];
		end

		always_comb begin
			trial = res_in + BIT;
			if (rem_in >= trial) begin
				rem_nx = rem_in - trial;
				res_nx = (res_in >> 1) + BIT;
			end else begin
				rem_nx = rem_in;
				res_nx = res_in >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= rem_nx;
			res_s[k] <= res_nx;
			tag_s[k] <= tag_in;
		end
	end

	assign out_vld  = vld_s[RT_W-1];
	assign out_root = res_s[RT_W-1][RT_W-1:0];
	assign out_tag  = tag_s[RT_W-1];

endmodule

@@ hw/rtl/circle_obstacle_clearance.sv @@
// top level: obstacle table in ram, scan pipeline for clearance queries
`timescale 1ns / 1ps
// Takes one word per start pulse while busy is low and gives exactly one result
// word on done for each, one cycle wide; the receiver cannot stall it. Clear,
// append and unused actions leave busy low and show their result in the cycle
// after the start edge. A query over N stored obstacles (N > 0) holds busy until
// its result shows on done: the obstacle ram is read one entry per cycle, and
// each entry passes a read stage, difference, square and sum stages, a 17-stage
// square root pipeline and a subtract stage before the running minimum. A query
// of an empty table answers in the cycle after the start edge with max_clearance.
module circle_obstacle_clearance #(
	parameter int MAX_OBSTACLES = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [coc_pkg::ACT_W-1:0]            action,
	input  logic signed [coc_pkg::POS_W-1:0]     pos_x,
	input  logic signed [coc_pkg::POS_W-1:0]     pos_y,
	input  logic [coc_pkg::RAD_W-1:0]            obstacle_radius,
	input  logic                                 cfg_we,
	input  logic [coc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [coc_pkg::CFG_DAT_W-1:0]        cfg_data,
	output logic                                 done,
	output logic signed [coc_pkg::CLR_W-1:0]     clearance,
	output logic                                 is_free,
	output logic [coc_pkg::CNTO_W-1:0]           obstacle_count,
	output logic                                 table_overflow
);

	import coc_pkg::*;

	localparam int AW    = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
	localparam int TAG_W = RAD_W + 1;

	// configuration
	logic [MRG_W-1:0]  margin_q;
	logic [MAXC_W-1:0] maxclr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MRG_W'(102);
			maxclr_q <= MAXC_W'(25600);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAFETY_MARGIN: margin_q <= cfg_data[MRG_W-1:0];
				REG_MAX_CLEARANCE: maxclr_q <= cfg_data[MAXC_W-1:0];
				default: ;
			endcase
		end
	end

	// control
	state_t           state_q;
	state_t           state_nx;
	logic             issue;
	logic             accept;
	logic             is_query;
	logic             is_append;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_m1;
	logic [AW-1:0]    rd_idx_q;
	logic             last_issue;
	logic             has_room;
	logic             v_s5;
	logic             l_s5;

	assign accept     = start && !busy;
	assign is_query   = (action == ACT_QUERY);
	assign is_append  = (action == ACT_APPEND);
	assign has_room   = (cnt_q < CNT_W'(MAX_OBSTACLES));
	assign cnt_m1     = cnt_q - CNT_W'(1);
	assign last_issue = (CNT_W'(rd_idx_q) == cnt_m1);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_query && (cnt_q != '0)) begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_issue) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (v_s5 && l_s5) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		busy  = 1'b1;
		issue = 1'b0;
		case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_SCAN: issue = 1'b1;
			ST_DRAIN: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				rd_idx_q <= '0;
				case (action)
					ACT_CLEAR: cnt_q <= '0;
					ACT_APPEND: begin
						if (has_room) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					default: ;
				endcase
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
		end
	end

	// obstacle table
	logic [ENTRY_W-1:0] rd_data;
	logic               wr_en;

	assign wr_en = accept && is_append && has_room;

	coc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_OBSTACLES),
		.ADDR_W(AW)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(cnt_q[AW-1:0]),
		.wdata({pos_x, pos_y, obstacle_radius}),
		.re   (issue),
		.raddr(rd_idx_q),
		.rdata(rd_data)
	);

	// query point, held for the whole scan
	logic signed [POS_W-1:0] qx_q;
	logic signed [POS_W-1:0] qy_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q <= pos_x;
			qy_q <= pos_y;
		end
	end

	// scan pipeline
	logic v_s1, l_s1, v_s2, l_s2, v_s3, l_s3, v_s4, l_s4;

	logic signed [POS_W-1:0] ox;
	logic signed [POS_W-1:0] oy;
	logic [RAD_W-1:0]        orad;

	assign ox   = rd_data[ENTRY_W-1 -: POS_W];
	assign oy   = rd_data[RAD_W +: POS_W];
	assign orad = rd_data[RAD_W-1:0];

	logic signed [DIF_W-1:0] dx_s2, dy_s2;
	logic [RAD_W-1:0]        r_s2, r_s3, r_s4;
	logic [SQ1_W-1:0]        sqx_s3, sqy_s3;
	logic [SQ_W-1:0]         sum_s4;
	logic signed [2*DIF_W-1:0] prod_x, prod_y;

	assign prod_x = dx_s2 * dx_s2;
	assign prod_y = dy_s2 * dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			l_s1 <= 1'b0;
			v_s2 <= 1'b0;
			l_s2 <= 1'b0;
			v_s3 <= 1'b0;
			l_s3 <= 1'b0;
			v_s4 <= 1'b0;
			l_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			l_s1 <= issue && last_issue;
			v_s2 <= v_s1;
			l_s2 <= l_s1;
			v_s3 <= v_s2;
			l_s3 <= l_s2;
			v_s4 <= v_s3;
			l_s4 <= l_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= DIF_W'(qx_q) - DIF_W'(ox);
		dy_s2  <= DIF_W'(qy_q) - DIF_W'(oy);
		r_s2   <= orad;
		sqx_s3 <= prod_x[SQ1_W-1:0];
		sqy_s3 <= prod_y[SQ1_W-1:0];
		r_s3   <= r_s2;
		sum_s4 <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
		r_s4   <= r_s3;
	end

	// square root, radius and last flag ride along as tag
	logic             rt_vld;
	logic [RT_W-1:0]  rt_root;
	logic [TAG_W-1:0] rt_tag;

	coc_isqrt #(
		.TAG_W(TAG_W)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (v_s4),
		.in_val  (sum_s4),
		.in_tag  ({l_s4, r_s4}),
		.out_vld (rt_vld),
		.out_root(rt_root),
		.out_tag (rt_tag)
	);

	logic signed [DST_W-1:0] d_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			l_s5 <= 1'b0;
		end else begin
			v_s5 <= rt_vld;
			l_s5 <= rt_vld && rt_tag[TAG_W-1];
		end
	end

	always_ff @(posedge clk) begin
		d_s5 <= $signed({1'b0, rt_root}) - $signed(DST_W'(rt_tag[RAD_W-1:0]))
			- $signed(DST_W'(margin_q));
	end

	// running minimum
	logic signed [DST_W-1:0] best_q;
	logic signed [DST_W-1:0] best_nx;
	logic signed [DST_W-1:0] maxclr_ext;

	assign maxclr_ext = $signed(DST_W'(maxclr_q));
	assign best_nx    = (d_s5 < best_q) ? d_s5 : best_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			best_q <= maxclr_ext;
		end else if (v_s5) begin
			best_q <= best_nx;
		end
	end

	// result word
	logic                    done_q;
	logic signed [CLR_W-1:0] clr_q;
	logic                    free_q;
	logic                    ovf_q;
	logic [CNT_W-1:0]        cnt_res;
	logic [CNT_W+CNTO_W-1:0] cnt_ext;
	logic [CNTO_W-1:0]       cnt_out_q;

	// count after this word
	always_comb begin
		cnt_res = cnt_q;
		case (action)
			ACT_CLEAR: cnt_res = '0;
			ACT_APPEND: begin
				if (has_room) begin
					cnt_res = cnt_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign cnt_ext = {{CNTO_W{1'b0}}, cnt_res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && !(is_query && (cnt_q != '0))) || (v_s5 && l_s5);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_out_q <= cnt_ext[CNTO_W-1:0];
			ovf_q     <= is_append && !has_room;
			if (is_query) begin
				clr_q  <= CLR_W'(maxclr_ext);
				free_q <= (maxclr_q != '0);
			end else begin
				clr_q  <= '0;
				free_q <= 1'b0;
			end
		end else if (v_s5 && l_s5) begin
			clr_q  <= best_nx[CLR_W-1:0];
			free_q <= (best_nx > 0);
		end
	end

	assign done           = done_q;
	assign clearance      = clr_q;
	assign is_free        = free_q;
	assign obstacle_count = cnt_out_q;
	assign table_overflow = ovf_q;

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for the circle obstacle clearance block
`timescale 1ns / 1ps
module tb_top;
	import coc_pkg::*;

	localparam int MAX_OBS = 64;
	localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [CLR_W-1:0]  clr;
		logic              free;
		logic [CNTO_W-1:0] cnt;
		logic              ovf;
	} answer_t;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [ACT_W-1:0]       action;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic [RAD_W-1:0]       obstacle_radius;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DAT_W-1:0]   cfg_data;
	logic                   done;
	logic signed [CLR_W-1:0] clearance;
	logic                   is_free;
	logic [CNTO_W-1:0]      obstacle_count;
	logic                   table_overflow;

	circle_obstacle_clearance #(
		.MAX_OBSTACLES(MAX_OBS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.obstacle_radius(obstacle_radius),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.clearance(clearance),
		.is_free(is_free),
		.obstacle_count(obstacle_count),
		.table_overflow(table_overflow)
	);

	// local copy of the obstacle table and registers
	logic signed [POS_W-1:0] tbl_x [MAX_OBS];
	logic signed [POS_W-1:0] tbl_y [MAX_OBS];
	logic [RAD_W-1:0]        tbl_r [MAX_OBS];
	int                      n_stored;
	logic [MRG_W-1:0]        margin;
	logic [MAXC_W-1:0]       ceiling;

	answer_t pending_answers[$];

	int idle_pct;
	int sent_items;
	int mismatches;
	int stall_cycles;
	int n_queries, n_appends, n_dropped, n_clears, n_unused, n_cfg_writes;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_root(longint v);
		longint root;
		longint trial;
		root = 0;
		for (int b = 17; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// applies one word to the local table and returns the answer it must produce
	function automatic answer_t obstacle_answer(input logic [ACT_W-1:0] act,
			input logic signed [POS_W-1:0] px, input logic signed [POS_W-1:0] py,
			input logic [RAD_W-1:0] rad);
		answer_t a;
		longint  best;
		longint  dx;
		longint  dy;
		longint  d;
		a = '0;
		case (act)
			ACT_CLEAR: begin
				n_stored = 0;
				n_clears++;
			end
			ACT_APPEND: begin
				n_appends++;
				if (n_stored < MAX_OBS) begin
					tbl_x[n_stored] = px;
					tbl_y[n_stored] = py;
					tbl_r[n_stored] = rad;
					n_stored++;
				end else begin
					a.ovf = 1'b1;
					n_dropped++;
				end
			end
			ACT_QUERY: begin
				n_queries++;
				best = longint'(ceiling);
				for (int i = 0; i < n_stored; i++) begin
					dx = longint'(px) - longint'(tbl_x[i]);
					dy = longint'(py) - longint'(tbl_y[i]);
					d = floor_root(dx * dx + dy * dy) - longint'(tbl_r[i])
						- longint'(margin);
					if (d < best)
						best = d;
				end
				a.clr = best[CLR_W-1:0];
				a.free = (best > 0);
			end
			default: begin
				n_unused++;
			end
		endcase
		a.cnt = CNTO_W'(n_stored);
		return a;
	endfunction

	// result checker and watchdog
	always @(posedge clk) begin : check
		answer_t want;
		answer_t got;
		if ((start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (done) begin
			got.clr = clearance;
			got.free = is_free;
			got.cnt = obstacle_count;
			got.ovf = table_overflow;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected word, clearance %0d free %0b count %0d overflow %0b",
						$time, $signed(got.clr), got.free, got.cnt, got.ovf);
			end else begin
				want = pending_answers.pop_front();
				if (got.clr !== want.clr || got.free !== want.free ||
						got.cnt !== want.cnt || got.ovf !== want.ovf) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: want clearance %0d free %0b count %0d overflow %0b",
							$time, $signed(want.clr), want.free, want.cnt, want.ovf);
						$display("%0t:  got clearance %0d free %0b count %0d overflow %0b",
							$time, $signed(got.clr), got.free, got.cnt, got.ovf);
					end
				end
			end
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", stall_cycles);
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_word(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic [RAD_W-1:0] r);
		answer_t ans;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		pos_x <= x;
		pos_y <= y;
		obstacle_radius <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		ans = obstacle_answer(act, x, y, r);
		pending_answers = {pending_answers, ans};
		if (act != ACT_NOP)
			sent_items++;
	endtask

	// wait until every answer is in and the block has gone quiet
	task automatic settle();
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == REG_SAFETY_MARGIN)
			margin = data[MRG_W-1:0];
		else
			ceiling = data;
		n_cfg_writes++;
	endtask

	task automatic set_config(input int m, input int c);
		settle();
		// upper bits of the margin word are junk and must be ignored
		write_reg(REG_SAFETY_MARGIN, {6'($urandom), MRG_W'(m)});
		write_reg(REG_MAX_CLEARANCE, MAXC_W'(c));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [POS_W-1:0] jitter(input logic [POS_W-1:0] base,
			input int spread);
		return POS_W'(int'(base) + int'($urandom_range(2 * spread)) - spread);
	endfunction

	function automatic logic [RAD_W-1:0] pick_radius();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return RAD_W'($urandom);
		endcase
	endfunction

	task automatic add_noise();
		if ($urandom_range(39) == 0)
			send_word(ACT_NOP, POS_W'($urandom), POS_W'($urandom), RAD_W'($urandom));
		if ($urandom_range(149) == 0)
			send_word(ACT_CLEAR, POS_W'($urandom), POS_W'($urandom), RAD_W'($urandom));
	endtask

	task automatic test_directed();
		send_word(ACT_QUERY, 16'h1234, 16'h8000, 10'h3ff);
		send_word(ACT_NOP, 16'hffff, 16'h7fff, 10'h155);
		send_word(ACT_APPEND, 16'h8000, 16'h8000, 10'h3ff);
		send_word(ACT_APPEND, 16'h7fff, 16'h7fff, 10'h000);
		send_word(ACT_APPEND, 16'h0000, 16'h0000, 10'h200);
		// opposite corners give the longest distance
		send_word(ACT_QUERY, 16'h7fff, 16'h8000, 10'h000);
		send_word(ACT_QUERY, 16'h8000, 16'h8000, 10'h2aa);
		send_word(ACT_QUERY, 16'h7fff, 16'h7fff, 10'h000);
		send_word(ACT_QUERY, 16'h0100, 16'hff00, 10'h000);
		send_word(ACT_NOP, 16'h0000, 16'h0000, 10'h000);
		send_word(ACT_CLEAR, 16'hffff, 16'hffff, 10'h3ff);
		send_word(ACT_QUERY, 16'h0000, 16'h0000, 10'h000);
		// zero ceiling: an empty table is not free
		set_config(1023, 0);
		send_word(ACT_QUERY, 16'h0042, 16'hff00, 10'h000);
		send_word(ACT_APPEND, 16'h4000, 16'hc000, 10'h3ff);
		send_word(ACT_QUERY, 16'h4000, 16'hc000, 10'h000);
		send_word(ACT_QUERY, 16'h8000, 16'h7fff, 10'h000);
		set_config(0, 65535);
		send_word(ACT_QUERY, 16'h8000, 16'h7fff, 10'h000);
		send_word(ACT_CLEAR, 16'h0000, 16'h0000, 10'h000);
		send_word(ACT_QUERY, 16'h5555, 16'haaaa, 10'h000);
		send_word(ACT_APPEND, 16'h0005, 16'h0005, 10'h000);
		send_word(ACT_QUERY, 16'h0005, 16'h0005, 10'h000);
		send_word(ACT_QUERY, 16'h0008, 16'h0009, 10'h000);
		set_config(102, 25600);
	endtask

	task automatic test_table_full();
		logic [POS_W-1:0] cx;
		logic [POS_W-1:0] cy;
		cx = POS_W'($urandom);
		cy = POS_W'($urandom);
		send_word(ACT_CLEAR, 16'h0000, 16'h0000, 10'h000);
		repeat (MAX_OBS)
			send_word(ACT_APPEND, jitter(cx, 3000), jitter(cy, 3000), pick_radius());
		// appends past the end are dropped
		repeat (3)
			send_word(ACT_APPEND, POS_W'($urandom), POS_W'($urandom), pick_radius());
		send_word(ACT_QUERY, jitter(tbl_x[0], 1500), jitter(tbl_y[0], 1500), 10'h000);
		send_word(ACT_QUERY, jitter(tbl_x[MAX_OBS-1], 1500), jitter(tbl_y[MAX_OBS-1], 1500),
			10'h000);
		send_word(ACT_NOP, 16'h0000, 16'h0000, 10'h000);
		send_word(ACT_CLEAR, 16'h0000, 16'h0000, 10'h000);
		send_word(ACT_APPEND, cx, cy, 10'h010);
		send_word(ACT_QUERY, jitter(cx, 500), jitter(cy, 500), 10'h000);
	endtask

	// one scene: optional clear, a cluster of obstacles, then queries around them
	task automatic run_episode();
		int n_obs;
		int n_q;
		int pick;
		logic [POS_W-1:0] cx;
		logic [POS_W-1:0] cy;
		cx = POS_W'($urandom);
		cy = POS_W'($urandom);
		if ($urandom_range(9) < 8)
			send_word(ACT_CLEAR, POS_W'($urandom), POS_W'($urandom), RAD_W'($urandom));
		n_obs = ($urandom_range(11) == 0) ? $urandom_range(72, 40) : $urandom_range(10);
		repeat (n_obs) begin
			add_noise();
			if ($urandom_range(4) == 0)
				send_word(ACT_APPEND, POS_W'($urandom), POS_W'($urandom), pick_radius());
			else
				send_word(ACT_APPEND, jitter(cx, 3000), jitter(cy, 3000), pick_radius());
		end
		n_q = $urandom_range(6, 1);
		repeat (n_q) begin
			add_noise();
			if (n_stored > 0 && $urandom_range(3) != 0) begin
				pick = $urandom_range(n_stored - 1);
				send_word(ACT_QUERY, jitter(tbl_x[pick], 1500), jitter(tbl_y[pick], 1500),
					RAD_W'($urandom));
			end else begin
				send_word(ACT_QUERY, POS_W'($urandom), POS_W'($urandom), RAD_W'($urandom));
			end
		end
	endtask

	// pct below zero picks a fresh idle rate for every scene
	task automatic test_random_traffic(input int pct, input int count, input int m,
			input int c);
		int target;
		set_config(m, c);
		target = sent_items + count;
		while (sent_items < target) begin
			if (pct >= 0)
				idle_pct = pct;
			else
				case ($urandom_range(2))
					0: idle_pct = 0;
					1: idle_pct = 66;
					default: idle_pct = 7;
				endcase
			run_episode();
		end
		idle_pct = 0;
	endtask

	initial begin
		start <= 1'b0;
		action <= ACT_CLEAR;
		pos_x <= '0;
		pos_y <= '0;
		obstacle_radius <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SAFETY_MARGIN;
		cfg_data <= '0;
		arst_n <= 1'b0;
		n_stored = 0;
		margin = MRG_W'(102);
		ceiling = MAXC_W'(25600);
		idle_pct = 0;
		sent_items = 0;
		mismatches = 0;
		stall_cycles = 0;
		n_queries = 0;
		n_appends = 0;
		n_dropped = 0;
		n_clears = 0;
		n_unused = 0;
		n_cfg_writes = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_full();
		test_random_traffic(0, 250, 0, 65535);
		test_random_traffic(66, 250, 1023, 4000);
		test_random_traffic(7, 250, $urandom_range(1023), $urandom_range(65535));
		test_random_traffic(-1, 250, 102, 25600);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d queries, %0d appends (%0d dropped when full), %0d clears, %0d unused",
			n_queries, n_appends, n_dropped, n_clears, n_unused);
		$display("%0d register writes, margins 0 to 1023, ceilings 0 to 65535; %0d mismatches",
			n_cfg_writes, mismatches);
		if (pending_answers.size() != 0)
			$display("%0d expected results never arrived", pending_answers.size());
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
